// ===== rtl/data_structure_trace_classifier_unit_assert.svh =====
// Assertion macros for the trace classifier.
`ifndef DATA_STRUCTURE_TRACE_CLASSIFIER_UNIT_ASSERT_SVH
`define DATA_STRUCTURE_TRACE_CLASSIFIER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DSTC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define DSTC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define DSTC_ASSERT_IMP(label, ante, cons)
`define DSTC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/dstc_pkg.sv =====
// ----------------------------------------------------------------------------
// Trace classifier package
// Shared widths, verdict codes and alive-flag positions.
// ----------------------------------------------------------------------------
`default_nettype none
package dstc_pkg;
	localparam int unsigned ADDR_BITS = 10;
	localparam int unsigned CNT_BITS = ADDR_BITS + 1;
	localparam int unsigned VAL_BITS = 16;
	localparam logic [CNT_BITS-1:0] CAPACITY = CNT_BITS'(1 << ADDR_BITS);
	localparam logic [2:0] V_IMPOSSIBLE = 3'd0;
	localparam logic [2:0] V_STACK = 3'd1;
	localparam logic [2:0] V_QUEUE = 3'd2;
	localparam logic [2:0] V_PRIO = 3'd3;
	localparam logic [2:0] V_NOT_SURE = 3'd4;
	localparam int unsigned A_STACK = 0;
	localparam int unsigned A_QUEUE = 1;
	localparam int unsigned A_HEAP = 2;
	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [CNT_BITS-1:0] cnt_t;
	typedef logic [VAL_BITS-1:0] val_t;
	typedef struct packed {
		logic start;
		logic pop;
		val_t value;
	} heap_cmd_t;
	typedef struct packed {
		logic done;
		logic match;
	} heap_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/dstc_heap.sv =====
// ----------------------------------------------------------------------------
// Trace classifier heap engine
// Max heap in one synchronous memory; insert sifts up, pop-compare sifts down.
// ----------------------------------------------------------------------------
`default_nettype none
`include "data_structure_trace_classifier_unit_assert.svh"
module dstc_heap (
	input wire logic clk,
	input wire logic arst_n,
	input wire dstc_pkg::heap_cmd_t cmd,
	input wire logic clear,
	output dstc_pkg::heap_rsp_t rsp
);
	localparam logic [3:0] H_IDLE = 4'd0;
	localparam logic [3:0] H_UP_RD = 4'd1;
	localparam logic [3:0] H_UP_CMP = 4'd2;
	localparam logic [3:0] H_TOP_RD = 4'd3;
	localparam logic [3:0] H_TOP_CMP = 4'd4;
	localparam logic [3:0] H_LAST_CMP = 4'd5;
	localparam logic [3:0] H_C1_RD = 4'd6;
	localparam logic [3:0] H_C2_RD = 4'd7;
	localparam logic [3:0] H_DN_CMP = 4'd8;
	localparam logic [3:0] H_DONE = 4'd9;

	dstc_pkg::val_t mem [0:(1 << dstc_pkg::ADDR_BITS)-1];
	dstc_pkg::val_t rd_q;
	logic [3:0] st_q;
	dstc_pkg::cnt_t cnt_q;
	dstc_pkg::cnt_t idx_q;
	dstc_pkg::cnt_t chi_q;
	dstc_pkg::val_t v_q;
	dstc_pkg::val_t c1_q;
	logic match_q;
	logic we;
	dstc_pkg::addr_t wa;
	dstc_pkg::val_t wd;
	dstc_pkg::addr_t ra;
	dstc_pkg::cnt_t par;
	dstc_pkg::cnt_t lc;

	assign par = (idx_q - dstc_pkg::cnt_t'(1)) >> 1;
	assign lc = {idx_q[dstc_pkg::CNT_BITS-2:0], 1'b1};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_comb begin
		we = 1'b0;
		wa = idx_q[dstc_pkg::ADDR_BITS-1:0];
		wd = v_q;
		ra = par[dstc_pkg::ADDR_BITS-1:0];
		case (st_q)
			H_IDLE: ra = '0;
			H_UP_RD: begin
				if (idx_q == '0) begin
					we = 1'b1;
				end
			end
			H_UP_CMP: begin
				we = 1'b1;
				if (rd_q < v_q) begin
					wd = rd_q;
				end
			end
			H_TOP_RD: ra = '0;
			H_TOP_CMP: ra = dstc_pkg::addr_t'(cnt_q - dstc_pkg::cnt_t'(1));
			H_LAST_CMP: ra = dstc_pkg::addr_t'(lc);
			H_C1_RD: begin
				ra = dstc_pkg::addr_t'(lc + dstc_pkg::cnt_t'(1));
				if (lc >= cnt_q) begin
					we = 1'b1;
				end
			end
			H_C2_RD: ra = dstc_pkg::addr_t'(chi_q);
			H_DN_CMP: begin
				we = 1'b1;
				ra = {chi_q[dstc_pkg::ADDR_BITS-2:0], 1'b1};
				if (chi_q < cnt_q && c1_q > v_q) begin
					wd = c1_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
			cnt_q <= '0;
			match_q <= 1'b0;
		end else if (clear) begin
			st_q <= H_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				H_IDLE: begin
					if (cmd.start) begin
						v_q <= cmd.value;
						if (cmd.pop) begin
							st_q <= H_TOP_RD;
						end else begin
							idx_q <= cnt_q;
							cnt_q <= cnt_q + dstc_pkg::cnt_t'(1);
							st_q <= H_UP_RD;
						end
					end
				end
				H_UP_RD: st_q <= (idx_q == '0) ? H_DONE : H_UP_CMP;
				H_UP_CMP: begin
					if (rd_q < v_q) begin
						idx_q <= par;
						st_q <= H_UP_RD;
					end else begin
						st_q <= H_DONE;
					end
				end
				H_TOP_RD: st_q <= H_TOP_CMP;
				H_TOP_CMP: begin
					match_q <= (cnt_q != '0) && (rd_q == v_q);
					if (cnt_q == '0 || rd_q != v_q) begin
						st_q <= H_DONE;
					end else begin
						cnt_q <= cnt_q - dstc_pkg::cnt_t'(1);
						idx_q <= '0;
						st_q <= (cnt_q == dstc_pkg::cnt_t'(1)) ? H_DONE : H_LAST_CMP;
					end
				end
				H_LAST_CMP: begin
					v_q <= rd_q;
					st_q <= H_C1_RD;
				end
				H_C1_RD: begin
					if (lc >= cnt_q) begin
						st_q <= H_DONE;
					end else begin
						c1_q <= rd_q;
						chi_q <= lc;
						st_q <= H_C2_RD;
					end
				end
				H_C2_RD: begin
					if (lc + dstc_pkg::cnt_t'(1) < cnt_q && rd_q > c1_q) begin
						chi_q <= lc + dstc_pkg::cnt_t'(1);
						c1_q <= rd_q;
					end
					st_q <= H_DN_CMP;
				end
				H_DN_CMP: begin
					if (chi_q < cnt_q && c1_q > v_q) begin
						idx_q <= chi_q;
						st_q <= H_C1_RD;
					end else begin
						st_q <= H_DONE;
					end
				end
				H_DONE: st_q <= H_IDLE;
				default: st_q <= H_IDLE;
			endcase
		end
	end

	assign rsp.done = (st_q == H_DONE);
	assign rsp.match = match_q;

	`DSTC_ASSERT_IMP(a_heap_start_idle, cmd.start, st_q == H_IDLE)
	`DSTC_ASSERT_NXT(a_heap_done_idle, st_q == H_DONE && !clear, st_q == H_IDLE)
	`DSTC_ASSERT_IMP(a_heap_cnt_cap, 1'b1, cnt_q <= dstc_pkg::CAPACITY)
endmodule
`default_nettype wire

// ===== rtl/data_structure_trace_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// Trace classifier top level
// Checks a push/pop trace against a stack, a queue and a max priority queue.
// ----------------------------------------------------------------------------
// One request is taken at a time. A stack or queue step goes through the read and
// compare states; a priority queue insert or removal walks the heap memory one
// level at a time.
// A verdict is emitted only for a request that ends a trace.
`default_nettype none
`include "data_structure_trace_classifier_unit_assert.svh"
module data_structure_trace_classifier_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic kind,
	input wire logic [15:0] value,
	input wire logic end_of_trace,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] verdict,
	output logic overflowed
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_CMP = 3'd2;
	localparam logic [2:0] S_HEAP = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	dstc_pkg::val_t stk [0:(1 << dstc_pkg::ADDR_BITS)-1];
	dstc_pkg::val_t fifo [0:(1 << dstc_pkg::ADDR_BITS)-1];
	dstc_pkg::val_t stk_rd_q;
	dstc_pkg::val_t fifo_rd_q;
	logic [2:0] st_q;
	dstc_pkg::cnt_t scnt_q;
	dstc_pkg::cnt_t fcnt_q;
	dstc_pkg::addr_t fhead_q;
	logic [2:0] alive_q;
	logic ovf_q;
	logic kind_q;
	logic eot_q;
	dstc_pkg::val_t val_q;
	logic full;
	logic clr;
	dstc_pkg::heap_cmd_t hcmd;
	dstc_pkg::heap_rsp_t hrsp;
	logic [2:0] alive_n;
	logic stk_hit;
	logic fifo_hit;
	logic [2:0] alive_pop;

	assign in_ready = (st_q == S_IDLE);
	assign full = alive_q != 3'b000 && scnt_q == dstc_pkg::CAPACITY;
	assign clr = (st_q == S_OUT) && out_ready;
	assign out_valid = (st_q == S_OUT);
	assign stk_hit = (scnt_q != '0) && (stk_rd_q == val_q);
	assign fifo_hit = (fcnt_q != '0) && (fifo_rd_q == val_q);

	always_ff @(posedge clk) begin
		if (st_q == S_RD && !kind_q && !full) begin
			if (alive_q[dstc_pkg::A_STACK]) begin
				stk[scnt_q[dstc_pkg::ADDR_BITS-1:0]] <= val_q;
			end
			if (alive_q[dstc_pkg::A_QUEUE]) begin
				fifo[fhead_q + fcnt_q[dstc_pkg::ADDR_BITS-1:0]] <= val_q;
			end
		end
		stk_rd_q <= stk[dstc_pkg::addr_t'(scnt_q - dstc_pkg::cnt_t'(1))];
		fifo_rd_q <= fifo[fhead_q];
	end

	assign hcmd.start = (st_q == S_RD) && alive_q[dstc_pkg::A_HEAP] && !(!kind_q && full);
	assign hcmd.pop = kind_q;
	assign hcmd.value = val_q;

	dstc_heap u_heap (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(hcmd),
		.clear(clr),
		.rsp(hrsp)
	);

	always_comb begin
		alive_n = alive_q;
		if (hrsp.done && kind_q && !hrsp.match) begin
			alive_n[dstc_pkg::A_HEAP] = 1'b0;
		end
	end

	// The stack count doubles as the common fill level of every live structure.
	always_comb begin
		alive_pop = alive_q;
		if (!stk_hit) begin
			alive_pop[dstc_pkg::A_STACK] = 1'b0;
		end
		if (!fifo_hit) begin
			alive_pop[dstc_pkg::A_QUEUE] = 1'b0;
		end
	end

	always_comb begin
		case (alive_q)
			3'b000: verdict = dstc_pkg::V_IMPOSSIBLE;
			3'b001: verdict = dstc_pkg::V_STACK;
			3'b010: verdict = dstc_pkg::V_QUEUE;
			3'b100: verdict = dstc_pkg::V_PRIO;
			default: verdict = dstc_pkg::V_NOT_SURE;
		endcase
	end
	assign overflowed = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			scnt_q <= '0;
			fcnt_q <= '0;
			fhead_q <= '0;
			alive_q <= 3'b111;
			ovf_q <= 1'b0;
			kind_q <= 1'b0;
			eot_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						val_q <= value;
						eot_q <= end_of_trace;
						st_q <= S_RD;
					end
				end
				S_RD: begin
					if (!kind_q) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else if (alive_q != 3'b000) begin
							scnt_q <= scnt_q + dstc_pkg::cnt_t'(1);
							fcnt_q <= fcnt_q + dstc_pkg::cnt_t'(1);
						end
					end
					st_q <= hcmd.start ? S_HEAP : S_CMP;
				end
				S_CMP: begin
					if (kind_q) begin
						alive_q <= alive_pop;
						if (alive_pop != 3'b000) begin
							scnt_q <= scnt_q - dstc_pkg::cnt_t'(1);
						end
						if (alive_q[dstc_pkg::A_QUEUE] && fifo_hit) begin
							fhead_q <= fhead_q + dstc_pkg::addr_t'(1);
							fcnt_q <= fcnt_q - dstc_pkg::cnt_t'(1);
						end
					end
					st_q <= eot_q ? S_OUT : S_IDLE;
				end
				S_HEAP: begin
					if (hrsp.done) begin
						alive_q <= alive_n;
						st_q <= S_CMP;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						scnt_q <= '0;
						fcnt_q <= '0;
						fhead_q <= '0;
						alive_q <= 3'b111;
						ovf_q <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`DSTC_ASSERT_IMP(a_top_out_hold, out_valid && !out_ready, ##1 out_valid)
	`DSTC_ASSERT_IMP(a_top_cnt_cap, 1'b1, scnt_q <= dstc_pkg::CAPACITY)
	`DSTC_ASSERT_NXT(a_top_clear, clr, alive_q == 3'b111 && !ovf_q)
endmodule
`default_nettype wire
